>>> design/steq_pkg.sv
package steq_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;

  localparam int KEY_W   = 32;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;
  localparam int END_W   = 11;

  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;

  localparam logic [APB_ADDR_W-1:0] REG_ENTRY_COUNT = 2'd0;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_PROBE_CMP,
    S_BACK,
    S_BACK_CMP,
    S_FWD,
    S_FWD_CMP,
    S_DONE
  } steq_state_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] first_index;
    logic [END_W-1:0]   end_index;
  } steq_result_t;

endpackage

>>> design/steq_engine.sv
module steq_engine #(
  parameter int TABLE_DEPTH = steq_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         kind,
  input  logic [steq_pkg::INDEX_W-1:0] entry_index,
  input  logic [steq_pkg::KEY_W-1:0]   entry_key,
  input  logic [steq_pkg::KEY_W-1:0]   search_key,
  input  logic [steq_pkg::COUNT_W-1:0] entry_count,
  input  logic                         out_free,
  output logic                         idle,
  output logic                         done,
  output steq_pkg::steq_result_t       result
);
  import steq_pkg::*;

  localparam int AW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW:0]   ONE_S = 1;
  localparam logic [CW-1:0] ONE_C = 1;
  localparam logic [AW-1:0] ONE_A = 1;

  logic [KEY_W-1:0] key_mem_r [TABLE_DEPTH];
  logic [KEY_W-1:0] rd_data_r;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;

  steq_state_t      state_r, state_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    lo_r, lo_nxt;
  logic [CW-1:0]    hi_x_r, hi_x_nxt;
  logic [AW-1:0]    mid_r, mid_nxt;
  logic [AW-1:0]    first_r, first_nxt;
  logic [CW-1:0]    end_r, end_nxt;
  logic             found_r, found_nxt;
  logic [CW:0]      mid_sum;
  logic [AW-1:0]    mid;
  logic [CW-1:0]    count_lim;

  assign wr_en   = start && (kind == KIND_LOAD) && (32'(entry_index) < 32'(TABLE_DEPTH));
  assign wr_addr = AW'(entry_index);
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_x_r} - ONE_S;
  assign mid     = AW'(mid_sum >> 1);
  assign count_lim = (32'(entry_count) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                           : CW'(entry_count);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem_r[wr_addr] <= entry_key;
    end
    rd_data_r <= key_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    key_r   <= key_nxt;
    count_r <= count_nxt;
    lo_r    <= lo_nxt;
    hi_x_r  <= hi_x_nxt;
    mid_r   <= mid_nxt;
    first_r <= first_nxt;
    end_r   <= end_nxt;
    found_r <= found_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    count_nxt = count_r;
    lo_nxt    = lo_r;
    hi_x_nxt  = hi_x_r;
    mid_nxt   = mid_r;
    first_nxt = first_r;
    end_nxt   = end_r;
    found_nxt = found_r;
    rd_addr   = '0;
    done      = 1'b0;
    idle      = 1'b0;
    case (state_r)
      S_IDLE: begin
        idle = 1'b1;
        if (start && (kind == KIND_QUERY)) begin
          key_nxt   = search_key;
          count_nxt = count_lim;
          lo_nxt    = '0;
          hi_x_nxt  = count_lim;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (lo_r < hi_x_r) begin
          rd_addr   = mid;
          mid_nxt   = mid;
          state_nxt = S_PROBE_CMP;
        end else begin
          found_nxt = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_PROBE_CMP: begin
        if (rd_data_r == key_r) begin
          found_nxt = 1'b1;
          first_nxt = mid_r;
          state_nxt = S_BACK;
        end else if (key_r < rd_data_r) begin
          hi_x_nxt  = CW'(mid_r);
          state_nxt = S_PROBE;
        end else begin
          lo_nxt    = CW'(mid_r) + ONE_C;
          state_nxt = S_PROBE;
        end
      end
      S_BACK: begin
        if (first_r == '0) begin
          end_nxt   = CW'(first_r) + ONE_C;
          state_nxt = S_FWD;
        end else begin
          rd_addr   = first_r - ONE_A;
          state_nxt = S_BACK_CMP;
        end
      end
      S_BACK_CMP: begin
        if (rd_data_r == key_r) begin
          first_nxt = first_r - ONE_A;
          state_nxt = S_BACK;
        end else begin
          end_nxt   = CW'(first_r) + ONE_C;
          state_nxt = S_FWD;
        end
      end
      S_FWD: begin
        if (end_r >= count_r) begin
          state_nxt = S_DONE;
        end else begin
          rd_addr   = AW'(end_r);
          state_nxt = S_FWD_CMP;
        end
      end
      S_FWD_CMP: begin
        if (rd_data_r <= key_r) begin
          end_nxt   = end_r + ONE_C;
          state_nxt = S_FWD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign result.found       = found_r;
  assign result.first_index = found_r ? INDEX_W'(32'(first_r)) : '0;
  assign result.end_index   = found_r ? END_W'(32'(end_r)) : '0;

`ifndef ASSERT_OFF
  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PROBE_CMP |-> lo_r < hi_x_r)
    else $error("probe issued on an empty range");

  a_fwd_past_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FWD || state_r == S_FWD_CMP) |-> end_r > CW'(first_r))
    else $error("forward scan not past first match");

  a_hit_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && found_r) |-> (end_r <= count_r && CW'(first_r) < count_r))
    else $error("hit result outside the searched range");

  a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> state_r == S_IDLE)
    else $error("engine not idle after delivering a result");
`endif

endmodule

>>> design/sorted_table_equal_range_search_core.sv
// Load beats: taken when the engine is idle, no result.
// Query beats: a binary search of P probes (at most clog2(count+1)); on a hit, a back step over B
// equal entries, then a forward scan of F entries that stops at a larger key or at entry_count
// (capped at TABLE_DEPTH). A miss gives found low with both indices zero.
// One item at a time; the next beat is taken while a result waits in the output register.
// Reset clears the sequencer, output valid and entry_count; the key table is not cleared.
module sorted_table_equal_range_search_core #(
  parameter int TABLE_DEPTH = steq_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [steq_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [steq_pkg::APB_DATA_W-1:0] pwdata,
  output logic [steq_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_kind,
  input  logic [steq_pkg::INDEX_W-1:0]    in_entry_index,
  input  logic [steq_pkg::KEY_W-1:0]      in_entry_key,
  input  logic [steq_pkg::KEY_W-1:0]      in_search_key,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_found,
  output logic [steq_pkg::INDEX_W-1:0]    out_first_index,
  output logic [steq_pkg::END_W-1:0]      out_end_index
);
  import steq_pkg::*;

  logic [COUNT_W-1:0] entry_count_r, entry_count_nxt;
  logic               out_valid_r, out_valid_nxt;
  steq_result_t       out_res_r, out_res_nxt;
  steq_result_t       eng_result;
  logic               eng_idle;
  logic               eng_done;
  logic               start;
  logic               out_free;
  logic               cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr == REG_ENTRY_COUNT);
  assign prdata   = (paddr == REG_ENTRY_COUNT) ? APB_DATA_W'(entry_count_r) : '0;
  assign in_ready = eng_idle;
  assign start    = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  steq_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .kind        (in_kind),
    .entry_index (in_entry_index),
    .entry_key   (in_entry_key),
    .search_key  (in_search_key),
    .entry_count (entry_count_r),
    .out_free    (out_free),
    .idle        (eng_idle),
    .done        (eng_done),
    .result      (eng_result)
  );

  always_comb begin
    entry_count_nxt = entry_count_r;
    if (cfg_wr) begin
      entry_count_nxt = COUNT_W'(pwdata);
    end
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (eng_done) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = eng_result;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      entry_count_r <= entry_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_res_r.found;
  assign out_first_index = out_res_r.first_index;
  assign out_end_index   = out_res_r.end_index;

endmodule

>>> tb/steq_checker.sv
`timescale 1ns / 1ps

module steq_checker #(
  parameter int TABLE_DEPTH = steq_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [steq_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [steq_pkg::APB_DATA_W-1:0] pwdata,
  input  logic [steq_pkg::APB_DATA_W-1:0] prdata,
  input  logic                            pready,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            in_kind,
  input  logic [steq_pkg::INDEX_W-1:0]    in_entry_index,
  input  logic [steq_pkg::KEY_W-1:0]      in_entry_key,
  input  logic [steq_pkg::KEY_W-1:0]      in_search_key,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            out_found,
  input  logic [steq_pkg::INDEX_W-1:0]    out_first_index,
  input  logic [steq_pkg::END_W-1:0]      out_end_index,
  output int                              mismatches,
  output int                              ranges_due
);
  import steq_pkg::*;

  logic [KEY_W-1:0]   stored_keys [TABLE_DEPTH];
  logic [COUNT_W-1:0] entry_count_q = '0;
  steq_result_t       pending_ranges [$];
  int                 fails = 0;
  int                 queued = 0;

  assign mismatches = fails;
  assign ranges_due = queued;

  function automatic steq_result_t predict_range(input logic [KEY_W-1:0] key);
    int           live;
    int           lo;
    int           hi;
    int           mid;
    int           first;
    int           stop;
    bit           hit;
    steq_result_t res;
    res  = '0;
    hit  = 1'b0;
    mid  = 0;
    live = (entry_count_q > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count_q);
    lo   = 0;
    hi   = live - 1;
    while (!hit && lo <= hi) begin
      mid = (lo + hi) / 2;
      if (stored_keys[mid] == key) begin
        hit = 1'b1;
      end else if (key < stored_keys[mid]) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    if (hit) begin
      first = mid;
      while (first > 0 && stored_keys[first-1] == key) first--;
      stop = first + 1;
      while (stop < live && stored_keys[stop] <= key) stop++;
      res.found       = 1'b1;
      res.first_index = INDEX_W'(first);
      res.end_index   = END_W'(stop);
    end
    return res;
  endfunction

  function automatic void check_field(input string what, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $display("%0t checker: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    steq_result_t want;
    if (!rst_n) begin
      entry_count_q = '0;
      pending_ranges.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_ranges.size() == 0) begin
          $display("%0t checker: unexpected result beat, expected none, actual %0b %0h %0h",
                   $time, out_found, out_first_index, out_end_index);
          fails++;
        end else begin
          want = pending_ranges.pop_front();
          check_field("found", want.found, out_found);
          check_field("first_index", want.first_index, out_first_index);
          check_field("end_index", want.end_index, out_end_index);
        end
      end
      if (in_valid && in_ready) begin
        if (in_kind == KIND_LOAD) begin
          if (int'(in_entry_index) < TABLE_DEPTH) stored_keys[in_entry_index] = in_entry_key;
        end else begin
          pending_ranges.push_back(predict_range(in_search_key));
        end
      end
      if (psel && penable && pready && paddr == REG_ENTRY_COUNT) begin
        if (pwrite) begin
          entry_count_q = pwdata[COUNT_W-1:0];
        end else begin
          check_field("entry_count readback", entry_count_q, prdata);
        end
      end
    end
    queued = pending_ranges.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import steq_pkg::*;

  localparam int DEPTH        = TABLE_DEPTH_DEF;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASES       = 15;
  localparam int TIMEOUT_NS   = 100_000_000;

  localparam logic [KEY_W-1:0] SEED_KEYS [8] = '{
    32'h0000_0000, 32'h0000_0000, 32'h0000_0005, 32'h0000_0005,
    32'h0000_0005, 32'h0000_0007, 32'hFFFF_FFFE, 32'hFFFF_FFFF
  };
  localparam logic [KEY_W-1:0] PROBE_KEYS [9] = '{
    32'h0000_0000, 32'h0000_0005, 32'h0000_0007, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
    32'h0000_0003, 32'h0000_0006, 32'h0000_0001, 32'h8000_0000
  };

  logic                  clk;
  logic                  rst_n          = 1'b0;
  logic                  psel           = 1'b0;
  logic                  penable        = 1'b0;
  logic                  pwrite         = 1'b0;
  logic [APB_ADDR_W-1:0] paddr          = '0;
  logic [APB_DATA_W-1:0] pwdata         = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic                  in_kind        = KIND_LOAD;
  logic [INDEX_W-1:0]    in_entry_index = '0;
  logic [KEY_W-1:0]      in_entry_key   = '0;
  logic [KEY_W-1:0]      in_search_key  = '0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic                  out_found;
  logic [INDEX_W-1:0]    out_first_index;
  logic [END_W-1:0]      out_end_index;
  int                    mismatches;
  int                    ranges_due;

  int                    send_idle_pct  = 35;
  int                    recv_idle_pct  = 83;
  int                    live_count     = 0;
  logic [KEY_W-1:0]      loaded_keys [DEPTH];

  sorted_table_equal_range_search_core #(.TABLE_DEPTH(DEPTH)) u_dut (.*);

  steq_checker #(.TABLE_DEPTH(DEPTH)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic push_item(input logic kind, input logic [INDEX_W-1:0] idx,
                           input logic [KEY_W-1:0] ekey, input logic [KEY_W-1:0] skey);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_entry_index <= idx;
    in_entry_key   <= ekey;
    in_search_key  <= skey;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic load_entry(input logic [INDEX_W-1:0] idx, input logic [KEY_W-1:0] key);
    loaded_keys[idx] = key;
    push_item(KIND_LOAD, idx, key, $urandom);
  endtask

  task automatic lookup(input logic [KEY_W-1:0] key);
    push_item(KIND_QUERY, INDEX_W'($urandom), $urandom, key);
  endtask

  task automatic drain(input int cycles);
    in_valid <= 1'b0;
    do @(negedge clk); while (ranges_due != 0);
    repeat (cycles) @(posedge clk);
  endtask

  // write, then read back in the following transfer
  task automatic set_entry_count(input logic [COUNT_W-1:0] value);
    live_count = (int'(value) > DEPTH) ? DEPTH : int'(value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ENTRY_COUNT;
    pwdata  <= {($urandom_range(1) ? (APB_DATA_W-COUNT_W)'($urandom) : '0), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic fill_sorted(input int n, input int unsigned span);
    logic [KEY_W:0] acc;
    case ($urandom_range(2))
      0: acc = '0;
      1: acc = (KEY_W+1)'($urandom >> 4);
      default: acc = {1'b0, {KEY_W{1'b1}}} - (KEY_W+1)'($urandom_range(2 * n));
    endcase
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(2) != 0) acc = acc + $urandom_range(span, 1);
      if (acc[KEY_W]) acc = {1'b0, {KEY_W{1'b1}}};
      load_entry(INDEX_W'(i), acc[KEY_W-1:0]);
    end
  endtask

  function automatic logic [KEY_W-1:0] pick_key(input int live);
    logic [KEY_W-1:0] k;
    int               sel;
    sel = $urandom_range(99);
    if (live == 0 || sel >= 85) return $urandom;
    k = loaded_keys[$urandom_range(live - 1)];
    if (sel < 55) return k;
    if (sel < 75) return $urandom_range(1) ? k + 1'b1 : k - 1'b1;
    return $urandom_range(1) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    lookup('0);
    for (int i = 0; i < 8; i++) load_entry(INDEX_W'(i), SEED_KEYS[i]);
    load_entry({INDEX_W{1'b1}}, 32'hA5A5_5A5A);
    drain(DRAIN_CYCLES);
    set_entry_count(COUNT_W'(8));
    for (int i = 0; i < 9; i++) lookup(PROBE_KEYS[i]);
    drain(DRAIN_CYCLES);
    set_entry_count(COUNT_W'(1));
    lookup('0);

    drain(DRAIN_CYCLES);
    fill_sorted(DEPTH, 1 << $urandom_range(20, 0));
    drain(DRAIN_CYCLES);
    set_entry_count(COUNT_W'(DEPTH));
    lookup(loaded_keys[0]);
    lookup(loaded_keys[DEPTH-1]);
    repeat (30) lookup(pick_key(live_count));
    drain(DRAIN_CYCLES);
    set_entry_count({COUNT_W{1'b1}});
    lookup(loaded_keys[DEPTH-1]);
    repeat (15) lookup(pick_key(live_count));

    for (int ph = 1; ph < PHASES; ph++) begin
      int n;
      int shape;
      drain(DRAIN_CYCLES);
      case (ph * 3 / PHASES)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct <= 83;
        end
        1: begin
          send_idle_pct = 83;
          recv_idle_pct <= 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      shape = $urandom_range(9);
      n = $urandom_range(32, 1);
      if (shape == 6) begin
        for (int i = 0; i < n; i++) load_entry(INDEX_W'(i), $urandom_range(7));
      end else begin
        fill_sorted(n, 1 << $urandom_range(27, 0));
      end
      drain(DRAIN_CYCLES);
      case (shape)
        7: set_entry_count(COUNT_W'($urandom_range(2047, n)));
        9: set_entry_count($urandom_range(1) ? {COUNT_W{1'b0}} : {COUNT_W{1'b1}});
        default: set_entry_count(COUNT_W'(n));
      endcase
      repeat (28) begin
        if (shape == 8 && $urandom_range(4) == 0) begin
          load_entry(INDEX_W'($urandom_range(n - 1)), $urandom);
        end else begin
          lookup(pick_key(live_count));
        end
      end
    end

    drain(64);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
